FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LDT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define LDT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Next-cycle implication that stays active during reset.
`define LDT_ASSERT_RST(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("reset check failed");

`endif

FILE: rtl/ldt_pkg.sv
// ----------------------------------------------------------------------------
// ldt_pkg
// Types and constants of the linear detrend engine.
// ----------------------------------------------------------------------------
package ldt_pkg;

   localparam int MAX_SAMPLES = 4096;
   localparam int SAMPLE_BITS = 24;
   localparam int FRAC_BITS   = 16;

   localparam int IDX_W    = $clog2(MAX_SAMPLES);
   localparam int CNT_W    = IDX_W + 1;
   localparam int SUM_W    = 37;
   localparam int SUMIW_W  = 49;
   localparam int MEAN_W   = 41;
   localparam int SLOPE_W  = 48;
   localparam int RES_W    = 25;
   localparam int K_W      = CNT_W + 1;
   localparam int DIV_W    = 70;
   localparam int DEN_W    = 37;
   localparam int DCNT_W   = $clog2(DIV_W);

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   localparam logic [47:0] RES_MAX     = 48'd16777215;
   localparam logic [47:0] RES_MIN_MAG = 48'd16777216;

   typedef struct packed {
      logic                           command;
      logic signed [SAMPLE_BITS-1:0]  sample;
      logic                           last;
   } ldt_req_type;

   typedef struct packed {
      logic signed [RES_W-1:0] residual;
      logic                    last_res;
      logic                    available;
   } ldt_rsp_type;

   typedef struct packed {
      logic              go;
      logic [DIV_W-1:0]  dividend;
      logic [DEN_W-1:0]  divisor;
   } ldt_div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_W-1:0]  quotient;
   } ldt_div_rsp_type;

endpackage

FILE: rtl/ldt_div.sv
// ----------------------------------------------------------------------------
// ldt_div
// Bit-serial restoring divider, one quotient bit per cycle, rounded half up.
// ----------------------------------------------------------------------------
module ldt_div (
   input  logic                     clock,
   input  logic                     reset,
   input  ldt_pkg::ldt_div_req_type div_req,
   output ldt_pkg::ldt_div_rsp_type div_rsp
);

   logic                              run_ff, run_in;
   logic                              fin_ff, fin_in;
   logic                              done_ff, done_in;
   logic [ldt_pkg::DCNT_W-1:0]        cnt_ff, cnt_in;
   logic [ldt_pkg::DIV_W-1:0]         num_ff, num_in;
   logic [ldt_pkg::DIV_W-1:0]         quo_ff, quo_in;
   logic [ldt_pkg::DEN_W:0]           rem_ff, rem_in;
   logic [ldt_pkg::DEN_W-1:0]         den_ff, den_in;
   logic [ldt_pkg::DEN_W:0]           rem_shift;
   logic                              ge;
   logic                              round_up;

   assign rem_shift = {rem_ff[ldt_pkg::DEN_W-1:0], num_ff[ldt_pkg::DIV_W-1]};
   assign ge        = rem_shift >= {1'b0, den_ff};
   // Round when twice the remainder reaches the divisor.
   assign round_up  = {rem_ff, 1'b0} >= {2'b00, den_ff};

   always_comb begin
      run_in  = run_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.go) begin
         run_in = 1'b1;
         cnt_in = '0;
         num_in = div_req.dividend;
         den_in = div_req.divisor;
         quo_in = '0;
         rem_in = '0;
      end else if (run_ff) begin
         num_in = {num_ff[ldt_pkg::DIV_W-2:0], 1'b0};
         quo_in = {quo_ff[ldt_pkg::DIV_W-2:0], ge};
         rem_in = ge ? (rem_shift - {1'b0, den_ff}) : rem_shift;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ldt_pkg::DCNT_W'(ldt_pkg::DIV_W - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         quo_in  = quo_ff + {{(ldt_pkg::DIV_W-1){1'b0}}, round_up};
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: rtl/ldt_resid.sv
// ----------------------------------------------------------------------------
// ldt_resid
// Residual datapath: registered slope product, then fit removal, rounding
// and saturation.
// ----------------------------------------------------------------------------
module ldt_resid (
   input  logic                                    clock,
   input  logic                                    step,
   input  logic signed [ldt_pkg::SAMPLE_BITS-1:0]  sample,
   input  logic signed [ldt_pkg::K_W-1:0]          offset,
   input  logic signed [ldt_pkg::MEAN_W-1:0]       mean,
   input  logic signed [ldt_pkg::SLOPE_W-1:0]      slope,
   output logic signed [ldt_pkg::RES_W-1:0]        residual
);

   localparam int PROD_W = ldt_pkg::SLOPE_W + ldt_pkg::K_W;

   logic signed [PROD_W-1:0]               prod_ff;
   logic signed [ldt_pkg::SAMPLE_BITS-1:0] y_ff;
   logic [63:0] fit2;
   logic [63:0] yv;
   logic [63:0] r;
   logic [63:0] mag;
   logic [63:0] rnd;
   logic [47:0] q;
   logic        neg;

   always_ff @(posedge clock) begin
      if (step) begin
         prod_ff <= slope * offset;
         y_ff    <= sample;
      end
   end

   always_comb begin
      fit2 = {{(64-ldt_pkg::MEAN_W-1){mean[ldt_pkg::MEAN_W-1]}}, mean, 1'b0}
           + {{(64-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      yv   = {{(64-ldt_pkg::SAMPLE_BITS-ldt_pkg::FRAC_BITS-1){y_ff[ldt_pkg::SAMPLE_BITS-1]}},
              y_ff, {(ldt_pkg::FRAC_BITS+1){1'b0}}};
      r    = yv - fit2;
      neg  = r[63];
      mag  = neg ? (64'd0 - r) : r;
      rnd  = {1'b0, mag[63:1]} + (64'd1 << (ldt_pkg::FRAC_BITS - 1));
      q    = rnd[ldt_pkg::FRAC_BITS +: 48];
      if (neg) begin
         if (q > ldt_pkg::RES_MIN_MAG) begin
            residual = ldt_pkg::RES_W'(25'd0 - ldt_pkg::RES_MIN_MAG[ldt_pkg::RES_W-1:0]);
         end else begin
            residual = ldt_pkg::RES_W'(25'd0 - q[ldt_pkg::RES_W-1:0]);
         end
      end else begin
         if (q > ldt_pkg::RES_MAX) begin
            residual = ldt_pkg::RES_MAX[ldt_pkg::RES_W-1:0];
         end else begin
            residual = q[ldt_pkg::RES_W-1:0];
         end
      end
   end

endmodule

FILE: rtl/linear_detrend_engine.sv
// Load: one transfer per cycle, busy stays low; a closing load raises busy unless draining.
// Record close: two 70-step runs of the bit-serial divider, skipped for records under two samples.
// Fetch while draining: busy through S_FETCH_RD and S_FETCH_OUT; the result strobe is registered from S_FETCH_OUT.
// Fetch while loading: empty result on the next cycle, busy stays low.
// Reset is synchronous, active high; the sample store is not cleared.
// ----------------------------------------------------------------------------
// linear_detrend_engine
// Stores one record of samples, fits a least-squares line and returns the
// samples with that line removed, one per fetch command.
// ----------------------------------------------------------------------------
module linear_detrend_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ldt_pkg::ldt_req_type req_data,
   output logic                 rsp_valid,
   output ldt_pkg::ldt_rsp_type rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_NSQ,
      S_DEN,
      S_PROD,
      S_SXY,
      S_MEAN_WAIT,
      S_SLOPE_WAIT,
      S_FETCH_RD,
      S_FETCH_OUT
   } state_type;

   localparam int NSQ_W  = 2 * ldt_pkg::CNT_W;
   localparam int PRD_W  = ldt_pkg::CNT_W + 1 + ldt_pkg::SUM_W;
   localparam int IWT_W  = ldt_pkg::CNT_W + 1 + ldt_pkg::SAMPLE_BITS;

   state_type                               state_ff, state_in;
   logic                                    draining_ff, draining_in;
   logic [ldt_pkg::CNT_W-1:0]               count_ff, count_in;
   logic [ldt_pkg::CNT_W-1:0]               ridx_ff, ridx_in;
   logic signed [ldt_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic signed [ldt_pkg::SUMIW_W-1:0]      sumiw_ff, sumiw_in;
   logic signed [ldt_pkg::MEAN_W-1:0]       mean_ff, mean_in;
   logic signed [ldt_pkg::SLOPE_W-1:0]      slope_ff, slope_in;
   logic [NSQ_W-1:0]                        nsq_ff, nsq_in;
   logic [ldt_pkg::DEN_W-1:0]               den_ff, den_in;
   logic signed [PRD_W-1:0]                 prod_ff, prod_in;
   logic signed [PRD_W-1:0]                 sxy_ff, sxy_in;
   logic signed [ldt_pkg::K_W-1:0]          k_ff, k_in;
   ldt_pkg::ldt_div_req_type                div_ff, div_in;
   ldt_pkg::ldt_rsp_type                    rsp_ff, rsp_in;
   logic                                    rsp_valid_ff, rsp_valid_in;

   logic signed [ldt_pkg::SAMPLE_BITS-1:0]  store_mem [ldt_pkg::MAX_SAMPLES];
   logic signed [ldt_pkg::SAMPLE_BITS-1:0]  rd_data_ff;

   ldt_pkg::ldt_div_rsp_type                div_rsp;
   logic signed [ldt_pkg::RES_W-1:0]        res_value;

   logic                                    accept;
   logic                                    mem_we;
   logic                                    mem_re;
   logic signed [IWT_W-1:0]                 iw_term;
   logic [ldt_pkg::SUM_W-1:0]               sum_mag;
   logic [PRD_W-1:0]                        sxy_mag;
   logic [PRD_W+2:0]                        sxy6;
   logic                                    is_last;

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;

   // A load is stored only while the record is open and has room.
   assign mem_we  = accept && (req_data.command == ldt_pkg::CMD_LOAD) && !draining_ff
                 && (count_ff < ldt_pkg::CNT_W'(ldt_pkg::MAX_SAMPLES));
   assign mem_re  = accept && (req_data.command == ldt_pkg::CMD_FETCH) && draining_ff;

   assign iw_term = $signed({1'b0, count_ff}) * req_data.sample;
   assign sum_mag = sum_ff[ldt_pkg::SUM_W-1] ? (ldt_pkg::SUM_W'(0) - sum_ff) : sum_ff;
   assign sxy_mag = sxy_ff[PRD_W-1] ? (PRD_W'(0) - sxy_ff) : sxy_ff;
   // Six times the magnitude, as a sum of two shifted copies.
   assign sxy6    = {2'b00, sxy_mag, 1'b0} + {1'b0, sxy_mag, 2'b00};
   assign is_last = (ridx_ff + 1'b1) >= count_ff;

   // Sample store: written by loads, read once per fetch while draining.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[count_ff[ldt_pkg::IDX_W-1:0]] <= req_data.sample;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[ridx_ff[ldt_pkg::IDX_W-1:0]];
      end
   end

   ldt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_ff),
      .div_rsp (div_rsp)
   );

   ldt_resid u_resid (
      .clock    (clock),
      .step     (state_ff == S_FETCH_RD),
      .sample   (rd_data_ff),
      .offset   (k_ff),
      .mean     (mean_ff),
      .slope    (slope_ff),
      .residual (res_value)
   );

   always_comb begin
      state_in     = state_ff;
      draining_in  = draining_ff;
      count_in     = count_ff;
      ridx_in      = ridx_ff;
      sum_in       = sum_ff;
      sumiw_in     = sumiw_ff;
      mean_in      = mean_ff;
      slope_in     = slope_ff;
      nsq_in       = nsq_ff;
      den_in       = den_ff;
      prod_in      = prod_ff;
      sxy_in       = sxy_ff;
      k_in         = k_ff;
      div_in       = div_ff;
      div_in.go    = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.command == ldt_pkg::CMD_LOAD) begin
                  // Loads during draining are dropped, last flag included.
                  if (!draining_ff) begin
                     if (mem_we) begin
                        sum_in   = sum_ff + {{(ldt_pkg::SUM_W-ldt_pkg::SAMPLE_BITS)
                                   {req_data.sample[ldt_pkg::SAMPLE_BITS-1]}},
                                   req_data.sample};
                        sumiw_in = sumiw_ff + {{(ldt_pkg::SUMIW_W-IWT_W)
                                   {iw_term[IWT_W-1]}}, iw_term};
                        count_in = count_ff + 1'b1;
                     end
                     if (req_data.last) begin
                        state_in = S_NSQ;
                     end
                  end
               end else if (draining_ff) begin
                  // Offset of this sample from the record center, doubled.
                  k_in     = $signed({ridx_ff, 1'b0}) - $signed({1'b0, count_ff - 1'b1});
                  state_in = S_FETCH_RD;
               end else begin
                  rsp_in.residual  = '0;
                  rsp_in.last_res  = 1'b0;
                  rsp_in.available = 1'b0;
                  rsp_valid_in     = 1'b1;
               end
            end
         end
         S_NSQ: begin
            nsq_in  = NSQ_W'(count_ff) * NSQ_W'(count_ff);
            ridx_in = '0;
            if (count_ff < ldt_pkg::CNT_W'(2)) begin
               // Short records pass through with a zero line.
               mean_in     = '0;
               slope_in    = '0;
               draining_in = 1'b1;
               state_in    = S_IDLE;
            end else begin
               state_in = S_DEN;
            end
         end
         S_DEN: begin
            den_in          = ldt_pkg::DEN_W'(ldt_pkg::DEN_W'(count_ff)
                            * ldt_pkg::DEN_W'(nsq_ff - 1'b1));
            div_in.go       = 1'b1;
            div_in.dividend = {{(ldt_pkg::DIV_W-ldt_pkg::SUM_W-ldt_pkg::FRAC_BITS){1'b0}},
                               sum_mag, {ldt_pkg::FRAC_BITS{1'b0}}};
            div_in.divisor  = ldt_pkg::DEN_W'(count_ff);
            state_in        = S_PROD;
         end
         S_PROD: begin
            prod_in  = $signed({1'b0, count_ff - 1'b1}) * sum_ff;
            state_in = S_SXY;
         end
         S_SXY: begin
            sxy_in   = $signed({sumiw_ff[ldt_pkg::SUMIW_W-1], sumiw_ff, 1'b0}) - prod_ff;
            state_in = S_MEAN_WAIT;
         end
         S_MEAN_WAIT: begin
            if (div_rsp.done) begin
               mean_in = sum_ff[ldt_pkg::SUM_W-1]
                       ? (ldt_pkg::MEAN_W'(0) - div_rsp.quotient[ldt_pkg::MEAN_W-1:0])
                       : div_rsp.quotient[ldt_pkg::MEAN_W-1:0];
               div_in.go       = 1'b1;
               div_in.dividend = {sxy6[ldt_pkg::DIV_W-ldt_pkg::FRAC_BITS-1:0],
                                  {ldt_pkg::FRAC_BITS{1'b0}}};
               div_in.divisor  = den_ff;
               state_in        = S_SLOPE_WAIT;
            end
         end
         S_SLOPE_WAIT: begin
            if (div_rsp.done) begin
               slope_in = sxy_ff[PRD_W-1]
                        ? (ldt_pkg::SLOPE_W'(0) - div_rsp.quotient[ldt_pkg::SLOPE_W-1:0])
                        : div_rsp.quotient[ldt_pkg::SLOPE_W-1:0];
               draining_in = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_FETCH_RD: begin
            state_in = S_FETCH_OUT;
         end
         S_FETCH_OUT: begin
            rsp_in.residual  = res_value;
            rsp_in.last_res  = is_last;
            rsp_in.available = 1'b1;
            rsp_valid_in     = 1'b1;
            ridx_in          = ridx_ff + 1'b1;
            if (is_last) begin
               // Record fully drained: open an empty one.
               count_in    = '0;
               sum_in      = '0;
               sumiw_in    = '0;
               ridx_in     = '0;
               draining_in = 1'b0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         draining_ff  <= 1'b0;
         count_ff     <= '0;
         ridx_ff      <= '0;
         sum_ff       <= '0;
         sumiw_ff     <= '0;
         mean_ff      <= '0;
         slope_ff     <= '0;
         div_ff.go    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         draining_ff  <= draining_in;
         count_ff     <= count_in;
         ridx_ff      <= ridx_in;
         sum_ff       <= sum_in;
         sumiw_ff     <= sumiw_in;
         mean_ff      <= mean_in;
         slope_ff     <= slope_in;
         div_ff.go    <= div_in.go;
         rsp_valid_ff <= rsp_valid_in;
      end
      nsq_ff          <= nsq_in;
      den_ff          <= den_in;
      prod_ff         <= prod_in;
      sxy_ff          <= sxy_in;
      k_ff            <= k_in;
      div_ff.dividend <= div_in.dividend;
      div_ff.divisor  <= div_in.divisor;
      rsp_ff          <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/ldt_checker.sv
// ----------------------------------------------------------------------------
// ldt_checker
// Port-level checks of the linear detrend engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ldt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input ldt_pkg::ldt_req_type req_data,
   input logic                 rsp_valid,
   input ldt_pkg::ldt_rsp_type rsp_data
);

   // An empty result carries neither a value nor a last mark.
   `LDT_ASSERT_IMP(a_empty_zero, clock, reset, rsp_valid && !rsp_data.available, rsp_data.residual == '0 && !rsp_data.last_res)

   // A load transfer never causes a result.
   `LDT_ASSERT_NXT(a_load_silent, clock, reset, start && !busy && req_data.command == ldt_pkg::CMD_LOAD, !rsp_valid)

   // A real residual leaves the fetch pipeline, which holds busy high.
   `LDT_ASSERT_IMP(a_res_after_busy, clock, reset, rsp_valid && rsp_data.available, $past(busy))

   // Reset leaves the engine idle with no result pending.
   `LDT_ASSERT_RST(a_reset_idle, clock, reset, !busy && !rsp_valid)

endmodule

bind linear_detrend_engine ldt_checker u_ldt_checker (.*);

FILE: sim/linear_detrend_engine_tb.sv
// ----------------------------------------------------------------------------
// linear_detrend_engine_tb
// Drives load and fetch commands into the detrend engine and checks every
// residual against a fixed-point least-squares line fit kept in the bench.
// ----------------------------------------------------------------------------
module linear_detrend_engine_tb;

   // Tracks the engine's record, works out each residual and compares.
   class detrend_scoreboard;
      logic [ldt_pkg::SAMPLE_BITS-1:0] sample_mem [ldt_pkg::MAX_SAMPLES];
      int unsigned  sample_cnt;
      logic [63:0]  sum_y;
      logic [63:0]  sum_iy;
      logic [63:0]  mean_fx;
      logic [63:0]  slope_fx;
      int unsigned  rd_idx;
      bit           draining;
      ldt_pkg::ldt_rsp_type expected_q [$];
      int           mismatches;
      int           residuals_seen;
      int           records_closed;

      function new();
         sample_cnt = 0;
         sum_y = '0;
         sum_iy = '0;
         mean_fx = '0;
         slope_fx = '0;
         rd_idx = 0;
         draining = 0;
         mismatches = 0;
         residuals_seen = 0;
         records_closed = 0;
      endfunction

      // round(num * mul * 2^FRAC_BITS / d), half away from zero, signed num.
      function logic [63:0] fixed_quotient(logic [63:0] num, logic [63:0] mul,
                                           logic [63:0] d);
         logic         neg;
         logic [63:0]  mag;
         logic [63:0]  prod;
         logic [127:0] wide;
         logic [127:0] q;
         logic [127:0] r;
         neg  = num[63];
         mag  = neg ? (64'd0 - num) : num;
         prod = mag * mul;
         wide = {48'd0, prod, 16'd0};
         q = wide / {64'd0, d};
         r = wide % {64'd0, d};
         if (r >= ({64'd0, d} - r))
            q = q + 1;
         return neg ? (64'd0 - q[63:0]) : q[63:0];
      endfunction

      function void close_record();
         logic [63:0] n;
         logic [63:0] sxy2;
         n = sample_cnt;
         if (n < 2) begin
            mean_fx = '0;
            slope_fx = '0;
         end else begin
            sxy2 = 2 * sum_iy - (n - 1) * sum_y;
            mean_fx = fixed_quotient(sum_y, 64'd1, n);
            slope_fx = fixed_quotient(sxy2, 64'd6, n * (n * n - 1));
         end
         rd_idx = 0;
         draining = 1;
         records_closed++;
      endfunction

      function ldt_pkg::ldt_rsp_type next_residual();
         ldt_pkg::ldt_rsp_type res;
         logic [63:0] n, y, k, fit2, diff, mag, q;
         logic        neg;
         n = sample_cnt;
         y = {{(64-ldt_pkg::SAMPLE_BITS){sample_mem[rd_idx][ldt_pkg::SAMPLE_BITS-1]}},
              sample_mem[rd_idx]};
         k = 2 * 64'(rd_idx) - (n - 1);
         fit2 = 2 * mean_fx + slope_fx * k;
         diff = (y << (ldt_pkg::FRAC_BITS + 1)) - fit2;
         neg = diff[63];
         mag = neg ? (64'd0 - diff) : diff;
         q = ((mag >> 1) + (64'd1 << (ldt_pkg::FRAC_BITS - 1))) >> ldt_pkg::FRAC_BITS;
         if (neg)
            res.residual = (q > 64'(ldt_pkg::RES_MIN_MAG))
                         ? ldt_pkg::RES_W'(64'd0 - 64'(ldt_pkg::RES_MIN_MAG))
                         : ldt_pkg::RES_W'(64'd0 - q);
         else
            res.residual = (q > 64'(ldt_pkg::RES_MAX)) ? ldt_pkg::RES_W'(ldt_pkg::RES_MAX)
                                                       : ldt_pkg::RES_W'(q);
         res.available = 1'b1;
         res.last_res = (rd_idx + 1 >= sample_cnt);
         rd_idx++;
         if (res.last_res) begin
            sample_cnt = 0;
            sum_y = '0;
            sum_iy = '0;
            rd_idx = 0;
            draining = 0;
         end
         return res;
      endfunction

      // Called for every accepted command transfer.
      function void note_input(ldt_pkg::ldt_req_type it);
         ldt_pkg::ldt_rsp_type none;
         logic [63:0] y;
         if (it.command == ldt_pkg::CMD_LOAD) begin
            if (draining)
               return;
            if (sample_cnt < ldt_pkg::MAX_SAMPLES) begin
               y = {{(64-ldt_pkg::SAMPLE_BITS){it.sample[ldt_pkg::SAMPLE_BITS-1]}},
                    it.sample};
               sample_mem[sample_cnt] = it.sample;
               sum_y += y;
               sum_iy += 64'(sample_cnt) * y;
               sample_cnt++;
            end
            if (it.last)
               close_record();
         end else if (!draining || rd_idx >= sample_cnt) begin
            none = '0;
            expected_q.push_back(none);
         end else begin
            expected_q.push_back(next_residual());
         end
      endfunction

      // Called for every result strobe.
      function void check_result(ldt_pkg::ldt_rsp_type got);
         ldt_pkg::ldt_rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result %0d last=%0b avail=%0b",
                        got.residual, got.last_res, got.available);
            return;
         end
         want = expected_q.pop_front();
         if (got.available)
            residuals_seen++;
         if (got.residual !== want.residual || got.last_res !== want.last_res ||
             got.available !== want.available) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                        want.residual, want.last_res, want.available,
                        got.residual, got.last_res, got.available);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 3000000;
   localparam int ITEMS_TARGET = 1350;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   ldt_pkg::ldt_req_type req_data = '0;
   logic                 rsp_valid;
   ldt_pkg::ldt_rsp_type rsp_data;

   detrend_scoreboard sb = new();
   int          cycles = 0;
   int          items_sent = 0;
   int          idle_pct = 0;

   linear_detrend_engine u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Results cannot be held off, so every strobe is checked at the edge that
   // closes its cycle. Values read here are the ones from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_data);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Presents one command and holds it until a transfer happens, that is an
   // edge with start high and busy low. start stays high into the next
   // command unless a random gap is taken.
   task automatic send(logic cmd, logic signed [ldt_pkg::SAMPLE_BITS-1:0] smp, logic lst);
      ldt_pkg::ldt_req_type it;
      it.command = cmd;
      it.sample = smp;
      it.last = lst;
      req_data <= it;
      start <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      sb.note_input(it);
      items_sent++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic logic signed [ldt_pkg::SAMPLE_BITS-1:0] clip_sample(longint v);
      if (v > 8388607)
         return 24'sd8388607;
      if (v < -8388608)
         return -24'sd8388608;
      return ldt_pkg::SAMPLE_BITS'(v);
   endfunction

   // One record of n loads and its fetches. Most records are a noisy ramp so
   // the fit is exercised; the rest use full-range random values. With noise
   // on, a few fetches land while loading and a few loads while draining.
   task automatic run_record(int n, bit noisy);
      int     kind;
      longint base, step;
      int     drained;
      logic signed [ldt_pkg::SAMPLE_BITS-1:0] v;
      kind = $urandom_range(9);
      base = longint'($urandom_range(16000000)) - 8000000;
      step = longint'($urandom_range(4000)) - 2000;
      for (int i = 0; i < n; i++) begin
         if (noisy && $urandom_range(99) < 5)
            send(ldt_pkg::CMD_FETCH, ldt_pkg::SAMPLE_BITS'($urandom),
                 1'($urandom_range(1)));
         case ($urandom_range(9))
            0: v = 24'sd8388607;
            1: v = -24'sd8388608;
            default: begin
               if (kind < 3)
                  v = ldt_pkg::SAMPLE_BITS'($urandom);
               else
                  v = clip_sample(base + step * i + $urandom_range(200) - 100);
            end
         endcase
         send(ldt_pkg::CMD_LOAD, v, i == n - 1);
      end
      drained = (n > ldt_pkg::MAX_SAMPLES) ? ldt_pkg::MAX_SAMPLES : n;
      for (int j = 0; j < drained; j++) begin
         if (noisy && $urandom_range(99) < 5)
            send(ldt_pkg::CMD_LOAD, ldt_pkg::SAMPLE_BITS'($urandom),
                 1'($urandom_range(1)));
         send(ldt_pkg::CMD_FETCH, '0, 1'b0);
      end
      if (noisy && $urandom_range(99) < 10)
         send(ldt_pkg::CMD_FETCH, '0, 1'b0);
   endtask

   initial begin
      int phase_idle [4];
      int goal;

      phase_idle = '{0, 49, 0, 20};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fetch with nothing loaded, a single-sample record, a two-sample
      // record at both extremes, a fetch while loading a three-sample record,
      // loads ignored while draining, and extra fetches after complete records.
      send(ldt_pkg::CMD_FETCH, '0, 1'b0);
      send(ldt_pkg::CMD_LOAD, -24'sd8388608, 1'b1);
      send(ldt_pkg::CMD_FETCH, '0, 1'b0);
      send(ldt_pkg::CMD_FETCH, '0, 1'b0);
      send(ldt_pkg::CMD_LOAD, 24'sd8388607, 1'b0);
      send(ldt_pkg::CMD_LOAD, -24'sd8388608, 1'b1);
      send(ldt_pkg::CMD_FETCH, '0, 1'b0);
      send(ldt_pkg::CMD_LOAD, 24'sd5, 1'b1);
      send(ldt_pkg::CMD_FETCH, '0, 1'b0);
      send(ldt_pkg::CMD_LOAD, -24'sd8388608, 1'b0);
      send(ldt_pkg::CMD_LOAD, 24'sd8388607, 1'b0);
      send(ldt_pkg::CMD_FETCH, '0, 1'b0);
      send(ldt_pkg::CMD_LOAD, -24'sd8388608, 1'b1);
      send(ldt_pkg::CMD_FETCH, '0, 1'b0);
      send(ldt_pkg::CMD_LOAD, 24'sd1, 1'b0);
      send(ldt_pkg::CMD_FETCH, '0, 1'b0);
      send(ldt_pkg::CMD_FETCH, '0, 1'b0);
      send(ldt_pkg::CMD_FETCH, '0, 1'b0);

      // Random phases at different sender gap rates.
      for (int p = 0; p < 4; p++) begin
         idle_pct = phase_idle[p];
         goal = items_sent + ITEMS_TARGET / 4;
         while (items_sent < goal)
            run_record(($urandom_range(3) == 0) ? $urandom_range(1, 3)
                                                : $urandom_range(4, 40), 1'b1);
         // Hold the sender off until every expected result is back.
         start <= 1'b0;
         do
            @(posedge clock);
         while (sb.pending() > 0);
      end

      repeat (200) @(posedge clock);

      $display("Run covered %0d command transfers, %0d records and %0d residuals.",
               items_sent, sb.records_closed, sb.residuals_seen);
      $display("Mismatches counted: %0d", sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/ldt_pkg.sv
rtl/ldt_div.sv
rtl/ldt_resid.sv
rtl/linear_detrend_engine.sv
rtl/ldt_checker.sv
sim/linear_detrend_engine_tb.sv
